@@ hdl/assert_macros.svh @@
// Assertion helpers shared by the RTL. Each check is sampled on the rising
// edge of clk and is ignored while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain invariant
`define NEGB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication
`define NEGB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

@@ hdl/negb_pkg.sv @@
package negb_pkg;

  // Field widths of the two channels
  localparam int OP_W    = 3;
  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 7;
  localparam int UVAL_W  = 64;
  localparam int SVAL_W  = 32;

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOAD = 3'd0;
  localparam logic [OP_W-1:0] OP_BITS = 3'd1;
  localparam logic [OP_W-1:0] OP_UE   = 3'd2;
  localparam logic [OP_W-1:0] OP_SE   = 3'd3;
  localparam logic [OP_W-1:0] OP_NEW  = 3'd4;

  // Emulation prevention byte, zero-run limit, widest raw read
  localparam logic [BYTE_W-1:0]  EPB_BYTE  = 8'h03;
  localparam logic [4:0]         MAX_ZEROS = 5'd31;
  localparam logic [COUNT_W-1:0] MAX_BITS  = 7'd64;

endpackage

@@ hdl/negb_cmd_if.sv @@
interface negb_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [negb_pkg::OP_W-1:0]           operation;
  logic [negb_pkg::BYTE_W-1:0]         payload_byte;
  logic [negb_pkg::COUNT_W-1:0]        bit_count;

  modport source (output valid, operation, payload_byte, bit_count, input ready);
  modport sink   (input valid, operation, payload_byte, bit_count, output ready);
endinterface

@@ hdl/negb_rsp_if.sv @@
interface negb_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [negb_pkg::UVAL_W-1:0]         unsigned_value;
  logic signed [negb_pkg::SVAL_W-1:0]  signed_value;
  logic                                past_end;

  modport source (output valid, unsigned_value, signed_value, past_end, input ready);
  modport sink   (input valid, unsigned_value, signed_value, past_end, output ready);
endinterface

@@ hdl/nal_exp_golomb_bit_reader.sv @@
// Exp-Golomb bit reader for one NAL unit payload. Load beats (operation 0)
// append bytes to an internal buffer of BUFFER_DEPTH bytes; read beats pull
// 0..64 raw bits, a ue code or an se code, MSB first, and return one result
// beat; operation 4 rewinds for a new unit and resets the loaded length; the
// stored bytes are not erased. A 0x03 after two stored zero bytes is dropped,
// bits past the loaded length read as zero and set past_end. A raw read steps
// through accept, one step per buffer byte it touches and per dropped 0x03,
// finish and result. A ue or se read steps through accept, the zero scan, one
// more step when the scan stops at the zero limit or the buffer end, the suffix,
// finish, add, signed map and result; the scan and the suffix take one step per
// byte they touch (the byte holding the stop bit counts in both) and one per
// dropped 0x03. The single buffer read port delivers one byte per cycle. No
// clearing pass is needed after reset. The result sits in an output register,
// so loads are taken while a result waits; a read that finishes while the
// previous result still waits holds its own result, and the input stalls until
// the older one leaves.
`include "assert_macros.svh"

module nal_exp_golomb_bit_reader #(
  parameter int BUFFER_DEPTH = 1024
) (
  input  logic          clk,
  input  logic          rst,
  negb_cmd_if.sink      cmd,
  negb_rsp_if.source    rsp
);

  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam int LW = AW + 1;
  localparam logic [LW-1:0] DEPTH_L = LW'(BUFFER_DEPTH);
  localparam int COUNT_W = negb_pkg::COUNT_W;

  typedef enum logic [2:0] {
    S_IDLE, S_BITS, S_ZEROS, S_SUM, S_SIGN, S_DONE
  } state_t;

  state_t state;

  // Buffer and its registered read port
  logic [negb_pkg::BYTE_W-1:0] store [BUFFER_DEPTH];
  logic [negb_pkg::BYTE_W-1:0] mem_q;

  // Read pointer state
  logic [LW-1:0] ll;
  logic [LW-1:0] rp;
  logic [LW-1:0] rp_next;
  logic [7:0]    hist1;
  logic [7:0]    hist2;
  logic [7:0]    cur_byte;
  logic [3:0]    bits_left;
  logic          is_pad;
  logic          skip_pend;

  // Request state
  logic [negb_pkg::OP_W-1:0]    op_reg;
  logic [negb_pkg::COUNT_W-1:0] rem;
  logic [4:0]                   zeros;
  logic [63:0]                  acc;
  logic                         past;
  logic [31:0]                  kval;
  logic [31:0]                  sval;

  // Result register
  logic        rsp_valid;
  logic [63:0] rsp_uval;
  logic [31:0] rsp_sval;
  logic        rsp_past;

  // Datapath
  logic        cmd_acc;
  logic        wr_en;
  logic        golomb;
  logic        need_fetch;
  logic        at_end;
  logic        skip;
  logic        zcond;
  logic        active;
  logic        fetch_adv;
  logic [7:0]  eb;
  logic [3:0]  eff_left;
  logic        eff_pad;
  logic [LW-1:0] rp_after;
  logic [7:0]  win;
  logic [3:0]  t;
  logic [7:0]  taken8;
  logic [63:0] acc_shift;
  logic [3:0]  lz;
  logic [4:0]  room;
  logic [3:0]  allowed;
  logic        found_one;
  logic [3:0]  zc;
  logic [3:0]  zadd;
  logic [32:0] k_inc;
  logic [31:0] mag;

  assign cmd.ready          = (state == S_IDLE);
  assign cmd_acc            = cmd.valid && cmd.ready;
  assign wr_en              = cmd_acc && (cmd.operation == negb_pkg::OP_LOAD) && (ll < DEPTH_L);
  assign golomb             = (op_reg != negb_pkg::OP_BITS);

  assign rsp.valid          = rsp_valid;
  assign rsp.unsigned_value = rsp_uval;
  assign rsp.signed_value   = rsp_sval;
  assign rsp.past_end       = rsp_past;

  // Byte fetch: take the buffer byte at rp, a pad zero at the end, or drop a 0x03
  always_comb begin
    need_fetch = (bits_left == 4'd0);
    at_end     = (rp >= ll);
    skip       = need_fetch && !at_end && (mem_q == negb_pkg::EPB_BYTE) &&
                 (rp >= LW'(2)) && (hist1 == 8'd0) && (hist2 == 8'd0);
    zcond      = skip_pend || ((zeros < negb_pkg::MAX_ZEROS) && (rp < ll));
    active     = ((state == S_BITS) && (rem != '0)) || ((state == S_ZEROS) && zcond);
    fetch_adv  = active && need_fetch && !at_end;
    eb         = need_fetch ? (at_end ? 8'd0 : mem_q) : cur_byte;
    eff_left   = need_fetch ? 4'd8 : bits_left;
    eff_pad    = need_fetch ? at_end : is_pad;
    rp_after   = (need_fetch && !at_end) ? rp + LW'(1) : rp;
    if (cmd_acc && (cmd.operation == negb_pkg::OP_NEW)) begin
      rp_next = '0;
    end else if (fetch_adv) begin
      rp_next = rp + LW'(1);
    end else begin
      rp_next = rp;
    end
  end

  // Bit chunking: remaining bits of the byte, aligned to the top
  always_comb begin
    win       = eb << (4'd8 - eff_left);
    t         = (rem < COUNT_W'(eff_left)) ? rem[3:0] : eff_left;
    taken8    = win >> (4'd8 - t);
    acc_shift = (acc << t) | 64'(taken8);
    lz = 4'd8;
    for (int i = 0; i < 8; i++) begin
      if (win[i]) lz = 4'(7 - i);
    end
    room      = negb_pkg::MAX_ZEROS - zeros;
    if (rp_after >= ll) begin
      allowed = 4'd1;
    end else if (room < 5'(eff_left)) begin
      allowed = room[3:0];
    end else begin
      allowed = eff_left;
    end
    found_one = (lz < allowed);
    zc        = found_one ? lz + 4'd1 : allowed;
    zadd      = found_one ? lz : allowed;
    k_inc     = {1'b0, kval} + 33'd1;
    mag       = k_inc[32:1];
  end

  // Buffer: write at the load pointer, read ahead at the next read pointer
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[ll[AW-1:0]] <= cmd.payload_byte;
    end
    if (wr_en && (ll == rp_next)) begin
      mem_q <= cmd.payload_byte;
    end else begin
      mem_q <= store[rp_next[AW-1:0]];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ll        <= '0;
      rp        <= '0;
      cur_byte  <= '0;
      bits_left <= '0;
      is_pad    <= 1'b0;
      skip_pend <= 1'b0;
      zeros     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      rp <= rp_next;
      if (fetch_adv) begin
        hist2 <= hist1;
        hist1 <= mem_q;
      end
      // result leaves; a new one from S_DONE takes its place below
      if (rsp_valid && rsp.ready && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_acc) begin
            op_reg <= cmd.operation;
            acc    <= '0;
            past   <= 1'b0;
            zeros  <= '0;
            case (cmd.operation)
              negb_pkg::OP_LOAD: begin
                if (ll < DEPTH_L) ll <= ll + LW'(1);
              end
              negb_pkg::OP_NEW: begin
                ll        <= '0;
                cur_byte  <= '0;
                bits_left <= '0;
                is_pad    <= 1'b0;
              end
              negb_pkg::OP_BITS: begin
                rem   <= (cmd.bit_count > negb_pkg::MAX_BITS) ? negb_pkg::MAX_BITS
                                                               : cmd.bit_count;
                state <= S_BITS;
              end
              negb_pkg::OP_UE, negb_pkg::OP_SE: begin
                skip_pend <= 1'b0;
                state     <= S_ZEROS;
              end
              default: ;
            endcase
          end
        end
        S_BITS: begin
          if (rem == '0) begin
            state <= golomb ? S_SUM : S_DONE;
          end else if (!skip) begin
            cur_byte  <= eb;
            bits_left <= eff_left - t;
            is_pad    <= eff_pad;
            past      <= past | eff_pad;
            acc       <= acc_shift;
            rem       <= rem - COUNT_W'(t);
          end
        end
        S_ZEROS: begin
          if (!zcond) begin
            rem   <= COUNT_W'(zeros);
            state <= S_BITS;
          end else if (skip) begin
            skip_pend <= 1'b1;
          end else begin
            skip_pend <= 1'b0;
            cur_byte  <= eb;
            bits_left <= eff_left - zc;
            is_pad    <= eff_pad;
            past      <= past | eff_pad;
            zeros     <= zeros + 5'(zadd);
            if (found_one) begin
              rem   <= COUNT_W'(zeros + 5'(zadd));
              state <= S_BITS;
            end
          end
        end
        S_SUM: begin
          kval  <= acc[31:0] + ((32'd1 << zeros) - 32'd1);
          state <= S_SIGN;
        end
        S_SIGN: begin
          sval  <= kval[0] ? mag : 32'd0 - mag;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_uval  <= golomb ? {32'd0, kval} : acc;
            rsp_sval  <= (op_reg == negb_pkg::OP_SE) ? sval : 32'd0;
            rsp_past  <= past;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks
  `NEGB_ASSERT(a_bits_left_range, bits_left <= 4'd8, "bit count of current byte above 8")
  `NEGB_ASSERT(a_ptr_order, (rp <= ll) && (ll <= DEPTH_L), "read pointer passed load length")
  `NEGB_ASSERT(a_zero_cap, zeros <= negb_pkg::MAX_ZEROS, "zero run above cap")
  `NEGB_ASSERT_IMPL(a_skip_after_fetch, skip_pend, $past(fetch_adv), "pending skip without fetch")
  `NEGB_ASSERT_IMPL(a_rsp_from_done, $rose(rsp_valid), $past(state) == S_DONE, "result beat out of order")

endmodule

@@ verif/tb_nal_exp_golomb_bit_reader.sv @@
`timescale 1ns / 100ps

module tb_nal_exp_golomb_bit_reader;

  localparam int DEPTH       = 1024;
  localparam int IDLE_LIMIT  = 3000;
  localparam int TAIL_CYCLES = 32;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_REPORTS = 10;
  localparam int PHASE_ITEMS = 30;

  // Operation codes the block ignores
  localparam logic [negb_pkg::OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [negb_pkg::OP_W-1:0] OP_SPARE_LAST  = 3'd7;

  typedef struct packed {
    logic [negb_pkg::UVAL_W-1:0] uval;
    logic [negb_pkg::SVAL_W-1:0] sval;
    logic                        past;
  } read_result_t;

  logic clk;
  logic rst;

  negb_cmd_if cmd_bus();
  negb_rsp_if rsp_bus();

  nal_exp_golomb_bit_reader #(.BUFFER_DEPTH(DEPTH)) i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_bus),
    .rsp (rsp_bus)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Shadow copy of the reader state
  logic [negb_pkg::BYTE_W-1:0] shadow_store [DEPTH];
  int unsigned                 loaded_len = 0;
  int unsigned                 rd_pos     = 0;
  int unsigned                 bits_left  = 0;
  logic [negb_pkg::BYTE_W-1:0] cur_byte   = '0;
  bit                          cur_is_pad = 1'b0;
  bit                          hit_past   = 1'b0;

  read_result_t predicted_results [$];
  int unsigned  items_sent      = 0;
  int unsigned  fail_count      = 0;
  int unsigned  send_idle_pct   = 0;
  int unsigned  ready_stall_pct = 0;
  bit           hold_request    = 1'b0;

  // ---------------------------------------------------------------------------
  // Reader behavior
  // ---------------------------------------------------------------------------

  // Next stored byte, dropping a 03 that follows two zero bytes
  function automatic logic [negb_pkg::BYTE_W-1:0] fetch_payload_byte();
    if (rd_pos < loaded_len && rd_pos >= 2 && shadow_store[rd_pos] == negb_pkg::EPB_BYTE &&
        shadow_store[rd_pos-1] == '0 && shadow_store[rd_pos-2] == '0)
      rd_pos++;
    if (rd_pos >= loaded_len) begin
      cur_is_pad = 1'b1;
      return '0;
    end
    cur_is_pad = 1'b0;
    rd_pos++;
    return shadow_store[rd_pos-1];
  endfunction

  function automatic bit take_bit();
    if (bits_left == 0) begin
      cur_byte  = fetch_payload_byte();
      bits_left = 8;
    end
    bits_left--;
    if (cur_is_pad)
      hit_past = 1'b1;
    return cur_byte[bits_left];
  endfunction

  function automatic logic [negb_pkg::UVAL_W-1:0] take_bits(int unsigned n);
    logic [negb_pkg::UVAL_W-1:0] v;
    v = '0;
    for (int unsigned i = 0; i < n; i++)
      v = {v[negb_pkg::UVAL_W-2:0], take_bit()};
    return v;
  endfunction

  // Zero scan stops at a one bit, at the loaded length or at the zero limit
  function automatic logic [31:0] decode_ue();
    int unsigned                 zeros;
    logic [negb_pkg::UVAL_W-1:0] suffix;
    zeros = 0;
    while (zeros < negb_pkg::MAX_ZEROS && rd_pos < loaded_len) begin
      if (take_bit())
        break;
      zeros++;
    end
    suffix = take_bits(zeros);
    return 32'(suffix + (64'd1 << zeros) - 64'd1);
  endfunction

  // Apply one accepted command beat; reads queue their expected result
  function automatic void advance_reader(logic [negb_pkg::OP_W-1:0] op,
                                         logic [negb_pkg::BYTE_W-1:0] pbyte,
                                         logic [negb_pkg::COUNT_W-1:0] count);
    read_result_t res;
    logic [31:0]  code;
    logic [32:0]  mag;
    res      = '0;
    hit_past = 1'b0;
    case (op)
      negb_pkg::OP_LOAD: begin
        if (loaded_len < DEPTH) begin
          shadow_store[loaded_len] = pbyte;
          loaded_len++;
          items_sent++;
        end
        return;
      end
      negb_pkg::OP_NEW: begin
        loaded_len = 0;
        rd_pos     = 0;
        bits_left  = 0;
        cur_byte   = '0;
        cur_is_pad = 1'b0;
        items_sent++;
        return;
      end
      negb_pkg::OP_BITS: begin
        res.uval = take_bits((count > negb_pkg::MAX_BITS) ? negb_pkg::MAX_BITS : count);
      end
      negb_pkg::OP_UE, negb_pkg::OP_SE: begin
        code     = decode_ue();
        res.uval = negb_pkg::UVAL_W'(code);
        if (op == negb_pkg::OP_SE) begin
          mag      = ({1'b0, code} + 33'd1) >> 1;
          res.sval = code[0] ? mag[31:0] : -mag[31:0];
        end
      end
      default: return;
    endcase
    res.past = hit_past;
    predicted_results.push_back(res);
    items_sent++;
  endfunction

  // ---------------------------------------------------------------------------
  // Command side
  // ---------------------------------------------------------------------------

  task automatic send_command(logic [negb_pkg::OP_W-1:0] op,
                              logic [negb_pkg::BYTE_W-1:0] pbyte = '0,
                              logic [negb_pkg::COUNT_W-1:0] count = '0);
    int unsigned gap;
    gap = 0;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
      gap++;
    if (gap != 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_bus.valid        <= 1'b1;
    cmd_bus.operation    <= op;
    cmd_bus.payload_byte <= pbyte;
    cmd_bus.bit_count    <= count;
    do @(posedge clk); while (!cmd_bus.ready);
    advance_reader(op, pbyte, count);
  endtask

  // Drop valid and hold until every predicted result has come back
  task automatic wait_for_results();
    cmd_bus.valid <= 1'b0;
    while (predicted_results.size() != 0)
      @(posedge clk);
  endtask

  // Zero-heavy so that long zero runs and 00 00 03 patterns show up often
  function automatic logic [negb_pkg::BYTE_W-1:0] random_payload_byte();
    case ($urandom_range(9))
      0, 1, 2: return '0;
      3:       return negb_pkg::EPB_BYTE;
      4:       return 8'h01;
      default: return negb_pkg::BYTE_W'($urandom_range(255));
    endcase
  endfunction

  task automatic send_random_read();
    logic [negb_pkg::COUNT_W-1:0] count;
    case ($urandom_range(7))
      0:       count = '0;
      1:       count = negb_pkg::MAX_BITS;
      2:       count = negb_pkg::COUNT_W'($urandom_range(127));
      default: count = negb_pkg::COUNT_W'($urandom_range(1, 16));
    endcase
    case ($urandom_range(9))
      0, 1, 2, 3: send_command(negb_pkg::OP_BITS, negb_pkg::BYTE_W'($urandom_range(255)), count);
      4, 5, 6:    send_command(negb_pkg::OP_UE, negb_pkg::BYTE_W'($urandom_range(255)), count);
      default:    send_command(negb_pkg::OP_SE, negb_pkg::BYTE_W'($urandom_range(255)), count);
    endcase
  endtask

  // New unit, a short payload, then reads that may run past its end
  task automatic send_random_unit();
    int unsigned n_bytes;
    int unsigned n_reads;
    n_bytes = ($urandom_range(15) == 0) ? $urandom_range(24, 96) : $urandom_range(0, 20);
    n_reads = $urandom_range(1, 14);
    send_command(negb_pkg::OP_NEW, negb_pkg::BYTE_W'($urandom_range(255)),
                 negb_pkg::COUNT_W'($urandom_range(127)));
    repeat (n_bytes)
      send_command(negb_pkg::OP_LOAD, random_payload_byte(),
                   negb_pkg::COUNT_W'($urandom_range(127)));
    repeat (n_reads) begin
      if ($urandom_range(9) == 0)
        send_command(negb_pkg::OP_LOAD, random_payload_byte(),
                     negb_pkg::COUNT_W'($urandom_range(127)));
      else
        send_random_read();
    end
  endtask

  // Any code with any fields
  task automatic send_noise();
    repeat ($urandom_range(1, 4))
      send_command(negb_pkg::OP_W'($urandom_range(OP_SPARE_LAST)),
                   negb_pkg::BYTE_W'($urandom_range(255)),
                   negb_pkg::COUNT_W'($urandom_range(127)));
  endtask

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Random stalls, or one long hold-off on request
  initial begin
    rsp_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        rsp_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        rsp_bus.ready <= !rst && ($urandom_range(99) >= ready_stall_pct);
      end
    end
  end

  function automatic void flag_mismatch(string what, read_result_t want, read_result_t got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%0t: %s: expected u=%h s=%0d past=%b, got u=%h s=%0d past=%b", $time, what,
               want.uval, $signed(want.sval), want.past,
               got.uval, $signed(got.sval), got.past);
  endfunction

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin
    read_result_t got;
    read_result_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      got.uval = rsp_bus.unsigned_value;
      got.sval = rsp_bus.signed_value;
      got.past = rsp_bus.past_end;
      if (predicted_results.size() == 0) begin
        flag_mismatch("result beat with no read outstanding", '0, got);
      end else begin
        want = predicted_results.pop_front();
        if (got.uval !== want.uval || got.sval !== want.sval || got.past !== want.past)
          flag_mismatch("result mismatch", want, got);
      end
    end
  end

  // Watchdog on cycles with no beat on either channel
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_directed();
    send_idle_pct   = 0;
    ready_stall_pct = 0;
    // reads on an empty unit: zero count, empty ue, bits past the end
    send_command(negb_pkg::OP_BITS, 8'hFF, '0);
    send_command(negb_pkg::OP_UE);
    send_command(negb_pkg::OP_BITS, '0, 7'd8);
    // 00 00 03 inside the payload and again as the last stored byte
    send_command(negb_pkg::OP_NEW);
    send_command(negb_pkg::OP_LOAD, 8'h00);
    send_command(negb_pkg::OP_LOAD, 8'h00);
    send_command(negb_pkg::OP_LOAD, negb_pkg::EPB_BYTE);
    send_command(negb_pkg::OP_LOAD, 8'h01);
    send_command(negb_pkg::OP_LOAD, 8'hFF);
    send_command(negb_pkg::OP_LOAD, 8'h80);
    send_command(negb_pkg::OP_LOAD, 8'h00);
    send_command(negb_pkg::OP_LOAD, 8'h00);
    send_command(negb_pkg::OP_LOAD, negb_pkg::EPB_BYTE);
    send_command(negb_pkg::OP_UE);
    send_command(negb_pkg::OP_SE);
    // oversized count acts as 64, runs into the skip at the end
    send_command(negb_pkg::OP_BITS, '0, 7'd127);
    send_command(negb_pkg::OP_BITS, 8'h00, negb_pkg::MAX_BITS);
    send_command(OP_SPARE_FIRST, 8'hFF, 7'd127);
    send_command(OP_SPARE_LAST, 8'hFF, 7'd127);
    // small se codes (+1 and 0), then a ue code and the trailing bits
    send_command(negb_pkg::OP_NEW);
    send_command(negb_pkg::OP_LOAD, 8'h5F);
    send_command(negb_pkg::OP_SE);
    send_command(negb_pkg::OP_SE);
    send_command(negb_pkg::OP_UE);
    send_command(negb_pkg::OP_BITS, '0, 7'd1);
    wait_for_results();
  endtask

  task automatic test_full_buffer();
    send_idle_pct   = 8;
    ready_stall_pct = 8;
    send_command(negb_pkg::OP_NEW);
    // zero run longer than the zero limit, then ones for a wide suffix
    repeat (4) send_command(negb_pkg::OP_LOAD, '0);
    repeat (5) send_command(negb_pkg::OP_LOAD, 8'hFF);
    while (loaded_len < DEPTH)
      send_command(negb_pkg::OP_LOAD, random_payload_byte());
    // these land on a full buffer and are dropped
    repeat (2) send_command(negb_pkg::OP_LOAD, negb_pkg::BYTE_W'($urandom_range(255)));
    send_command(negb_pkg::OP_SE);
    while (rd_pos < loaded_len) begin
      if ($urandom_range(3) == 0)
        send_random_read();
      else
        send_command(negb_pkg::OP_BITS, '0, negb_pkg::MAX_BITS);
    end
    repeat (4) send_random_read();
    wait_for_results();
  endtask

  task automatic test_random_phases();
    int unsigned idle_plan  [4] = '{0, 80, 0, 8};
    int unsigned stall_plan [4] = '{0, 0, 80, 8};
    int unsigned target;
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct   = idle_plan[phase];
      ready_stall_pct = stall_plan[phase];
      target          = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        if ($urandom_range(7) == 0)
          send_noise();
        else
          send_random_unit();
      end
    end
    wait_for_results();
  endtask

  // Receiver holds off while reads keep coming, so the input backs up
  task automatic test_output_hold_off();
    send_idle_pct   = 0;
    ready_stall_pct = 0;
    send_command(negb_pkg::OP_NEW);
    repeat (40) send_command(negb_pkg::OP_LOAD, random_payload_byte());
    hold_request = 1'b1;
    repeat (12) begin
      send_random_read();
      send_command(negb_pkg::OP_LOAD, random_payload_byte());
    end
    wait_for_results();
  endtask

  // Sender stops until the block is empty, then picks up the same unit
  task automatic test_drain_pause();
    send_idle_pct   = 0;
    ready_stall_pct = 80;
    send_command(negb_pkg::OP_NEW);
    repeat (16) send_command(negb_pkg::OP_LOAD, random_payload_byte());
    repeat (3) send_random_read();
    wait_for_results();
    repeat (3) send_random_read();
    // bytes loaded after the reads ran dry are readable at once
    repeat (4) send_command(negb_pkg::OP_LOAD, random_payload_byte());
    repeat (4) send_random_read();
    wait_for_results();
  endtask

  initial begin
    rst                  = 1'b1;
    cmd_bus.valid        = 1'b0;
    cmd_bus.operation    = negb_pkg::OP_LOAD;
    cmd_bus.payload_byte = '0;
    cmd_bus.bit_count    = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_full_buffer();
    test_random_phases();
    test_output_hold_off();
    test_drain_pause();

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && predicted_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
